### sv/dmwsm_pkg.sv
package dmwsm_pkg;

   // Field and register widths
   localparam int SPEED_W  = 16;
   localparam int COUNT_W  = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int FRAC_W   = 4;
   localparam int PROD_W   = 32;
   localparam int DIVD_W   = 36;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 56;

   // Number of quotient bits produced by the shared divider
   localparam int DIV_STEPS  = 16;
   localparam int DIV_CNT_W  = 4;

   // Default parameter values
   localparam int TICKS_PER_MS_DEF = 10;
   localparam int FAST_DIVISOR_DEF = 100;

   // Register values after reset
   localparam logic [CSR_W-1:0] THRESHOLD_RST = 16'd10;
   localparam logic [CSR_W-1:0] WINDOW_RST    = 16'd100;
   localparam logic [CSR_W-1:0] TOGGLE_RST    = 16'd500;
   localparam logic [CSR_W-1:0] GAIN_RST      = 16'd322;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD  = 3'd0,
      CSR_WINDOW     = 3'd1,
      CSR_TOGGLE     = 3'd2,
      CSR_GAIN_LEFT  = 3'd3,
      CSR_GAIN_RIGHT = 3'd4
   } csr_index_type;

   // Wheel selector
   typedef enum logic {
      WHEEL_LEFT  = 1'b0,
      WHEEL_RIGHT = 1'b1
   } wheel_sel_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic          tick;
      wheel_sel_type sel;
      logic          mul;
      logic          scale;
      logic          div_step;
      logic          store;
      logic          decide;
      logic          emit;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic need_meas;
      logic sat;
   } sts_type;

   // Controller states
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CHECK  = 8'b0000_0010,
      ST_MUL    = 8'b0000_0100,
      ST_SCALE  = 8'b0000_1000,
      ST_DIV    = 8'b0001_0000,
      ST_STORE  = 8'b0010_0000,
      ST_DECIDE = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

endpackage

### sv/dmwsm_ctrl.sv
module dmwsm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output dmwsm_pkg::cmd_type cmd,
   input  dmwsm_pkg::sts_type sts
);
   import dmwsm_pkg::*;

   state_type             state_ff, state_in;
   wheel_sel_type         sel_ff, sel_in;
   logic [DIV_CNT_W-1:0]  step_ff, step_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  emit_ok;

   // The result slot is free when empty or being drained this cycle
   assign emit_ok    = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;

   // Sequencer: per request, measure when due and decide for the left wheel, then the right
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      cmd          = '0;
      cmd.sel      = sel_ff;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.tick = 1'b1;
               sel_in   = WHEEL_LEFT;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = sts.need_meas ? ST_MUL : ST_DECIDE;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            step_in   = '0;
            state_in  = sts.sat ? ST_STORE : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (sel_ff == WHEEL_LEFT) begin
               sel_in   = WHEEL_RIGHT;
               state_in = ST_CHECK;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_ok) begin
               cmd.emit     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= WHEEL_LEFT;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

### sv/dmwsm_dp.sv
module dmwsm_dp #(
   parameter int TICKS_PER_MS = dmwsm_pkg::TICKS_PER_MS_DEF,
   parameter int FAST_DIVISOR = dmwsm_pkg::FAST_DIVISOR_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [1:0]                            pulse,
   input  logic                                  csr_we,
   input  logic [dmwsm_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  logic [dmwsm_pkg::CSR_W-1:0]           csr_wdata,
   input  dmwsm_pkg::cmd_type                    cmd,
   output dmwsm_pkg::sts_type                    sts,
   output logic [dmwsm_pkg::RSP_DATA_W-1:0]      rsp_data
);
   import dmwsm_pkg::*;

   typedef struct packed {
      logic [COUNT_W-1:0] elapsed;
      logic [COUNT_W-1:0] age;
      logic [COUNT_W-1:0] count;
      logic [SPEED_W-1:0] speed;
      logic               mode;
   } wheel_type;

   // Configuration registers
   logic [CSR_W-1:0] threshold_ff, window_ff, toggle_ff, gain_l_ff, gain_r_ff;

   // Measurement state
   logic [FRAC_W-1:0] frac_ff, frac_in;
   wheel_type         wheel_ff [2];
   wheel_type         wheel_in [2];
   logic [1:0]        fresh_ff, fresh_in;

   // Multiplier and divider registers
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [SPEED_W-1:0] rem_ff, rem_in;
   logic [SPEED_W-1:0] quo_ff, quo_in;
   logic [SPEED_W-1:0] dvs_ff, dvs_in;
   logic               sat_ff, sat_in;

   // Result register
   logic [RSP_DATA_W-1:0] rsp_ff, rsp_in;

   wheel_type          cur;
   logic [CSR_W-1:0]   gain;
   logic [FRAC_W-1:0]  frac_next;
   logic               ms_step;
   logic [DIVD_W-1:0]  dividend;
   logic [SPEED_W-1:0] divisor;
   logic [SPEED_W:0]   trial;
   logic [SPEED_W:0]   diff;
   logic [SPEED_W:0]   sum;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // Selected wheel and its sensor gain
   assign cur  = wheel_ff[cmd.sel];
   assign gain = (cmd.sel == WHEEL_RIGHT) ? gain_r_ff : gain_l_ff;

   // A fast wheel measures at the end of its window, a slow one on its first pulse
   assign sts.need_meas = cur.mode ? (cur.elapsed >= window_ff) : (cur.count != '0);

   // Dividend and divisor for the selected wheel's mode
   always_comb begin
      if (cur.mode) begin
         dividend = {{(DIVD_W-PROD_W){1'b0}}, prod_ff};
         divisor  = SPEED_W'(FAST_DIVISOR);
      end else begin
         dividend = {1'b0, prod_ff, 3'b000} + {3'b000, prod_ff, 1'b0};
         divisor  = (cur.elapsed == '0) ? SPEED_W'(1) : cur.elapsed;
      end
   end

   // The quotient overflows sixteen bits exactly when the top part reaches the divisor
   assign sts.sat = (dividend[DIVD_W-1:SPEED_W] >= {4'b0000, divisor});

   // One restoring division step
   assign trial = {rem_ff, quo_ff[SPEED_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   assign frac_next = frac_ff + 1'b1;
   assign ms_step   = (frac_next >= FRAC_W'(TICKS_PER_MS));
   assign sum       = {1'b0, wheel_ff[0].speed} + {1'b0, wheel_ff[1].speed};

   // Per-wheel state updates
   always_comb begin
      frac_in     = frac_ff;
      fresh_in    = fresh_ff;
      wheel_in[0] = wheel_ff[0];
      wheel_in[1] = wheel_ff[1];

      if (cmd.tick) begin
         frac_in  = ms_step ? '0 : frac_next;
         fresh_in = '0;
         for (int i = 0; i < 2; i++) begin
            if (ms_step) begin
               wheel_in[i].elapsed = sat_inc(wheel_ff[i].elapsed);
               wheel_in[i].age     = sat_inc(wheel_ff[i].age);
            end
            if (pulse[i]) begin
               wheel_in[i].count = sat_inc(wheel_ff[i].count);
            end
         end
      end

      if (cmd.store) begin
         wheel_in[cmd.sel].speed   = sat_ff ? '1 : quo_ff;
         wheel_in[cmd.sel].count   = '0;
         wheel_in[cmd.sel].elapsed = '0;
         fresh_in[cmd.sel]         = 1'b1;
      end

      if (cmd.decide && (cur.age >= toggle_ff)) begin
         wheel_in[cmd.sel].mode = (cur.speed > threshold_ff);
         wheel_in[cmd.sel].age  = '0;
      end
   end

   // Multiplier and divider
   always_comb begin
      prod_in = prod_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      sat_in  = sat_ff;

      if (cmd.mul) begin
         prod_in = cur.count * gain;
      end
      if (cmd.scale) begin
         sat_in = sts.sat;
         rem_in = dividend[2*SPEED_W-1:SPEED_W];
         quo_in = dividend[SPEED_W-1:0];
         dvs_in = divisor;
      end
      if (cmd.div_step) begin
         if (!diff[SPEED_W]) begin
            rem_in = diff[SPEED_W-1:0];
            quo_in = {quo_ff[SPEED_W-2:0], 1'b1};
         end else begin
            rem_in = trial[SPEED_W-1:0];
            quo_in = {quo_ff[SPEED_W-2:0], 1'b0};
         end
      end
   end

   // Result word: speeds, mean, modes and fresh flags
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.emit) begin
         rsp_in = {4'b0000, fresh_ff[1], fresh_ff[0], wheel_ff[1].mode, wheel_ff[0].mode,
                   sum[SPEED_W:1], wheel_ff[1].speed, wheel_ff[0].speed};
      end
   end

   assign rsp_data = rsp_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RST;
         window_ff    <= WINDOW_RST;
         toggle_ff    <= TOGGLE_RST;
         gain_l_ff    <= GAIN_RST;
         gain_r_ff    <= GAIN_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_THRESHOLD:  threshold_ff <= csr_wdata;
            CSR_WINDOW:     window_ff    <= csr_wdata;
            CSR_TOGGLE:     toggle_ff    <= csr_wdata;
            CSR_GAIN_LEFT:  gain_l_ff    <= csr_wdata;
            CSR_GAIN_RIGHT: gain_r_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Measurement state
   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff     <= '0;
         fresh_ff    <= '0;
         wheel_ff[0] <= '0;
         wheel_ff[1] <= '0;
      end else begin
         frac_ff     <= frac_in;
         fresh_ff    <= fresh_in;
         wheel_ff[0] <= wheel_in[0];
         wheel_ff[1] <= wheel_in[1];
      end
   end

   // Arithmetic and result payload
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      sat_ff  <= sat_in;
      rsp_ff  <= rsp_in;
   end

endmodule

### sv/dual_mode_wheel_speed_meter.sv
// Dual-mode wheel speed meter.
// Each request on the req_ channel is one sub-millisecond tick carrying a pulse
// flag per wheel; TICKS_PER_MS requests make one millisecond. Every request
// yields exactly one result on the rsp_ channel with both wheel speeds, their
// mean, the measurement modes and flags marking which speeds were recomputed.
// A fast-mode wheel counts pulses over a window and scales the count; a
// slow-mode wheel divides its scaled count by the elapsed milliseconds.
// Each request runs from acceptance to result as: per wheel a check and a mode
// decision, and when a measurement is due a multiply, a scaling, sixteen steps
// of the shared one-bit-per-cycle restoring divider and a store (a saturating
// quotient skips the divider); then the output register is loaded.
// Requests are handled one at a time: a new request is taken only once the
// result of the last one has been loaded into the output register.
// The result sits in an output register, so a new request is taken while a
// stalled result waits; the next result is held back until it is taken.
// The user must write registers over the csr_ port only while the block is idle; the block does not enforce this.
// Synchronous reset restores register defaults, clears all counters and
// speeds, puts both wheels in slow mode and empties the output register.
module dual_mode_wheel_speed_meter #(
   parameter int TICKS_PER_MS = dmwsm_pkg::TICKS_PER_MS_DEF,
   parameter int FAST_DIVISOR = dmwsm_pkg::FAST_DIVISOR_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [0] pulse_left, [1] pulse_right, [7:2] zero
   input  logic [dmwsm_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [15:0] speed_left, [31:16] speed_right, [47:32] speed_mean,
   // [48] mode_left, [49] mode_right, [50] fresh_left, [51] fresh_right, [55:52] zero
   output logic [dmwsm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                  csr_we,
   input  logic [dmwsm_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  logic [dmwsm_pkg::CSR_W-1:0]           csr_wdata
);
   import dmwsm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   dmwsm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Counters, registers and arithmetic
   dmwsm_dp #(
      .TICKS_PER_MS (TICKS_PER_MS),
      .FAST_DIVISOR (FAST_DIVISOR)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .pulse     (req_tdata[1:0]),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_tdata)
   );

endmodule

### test/tb_dual_mode_wheel_speed_meter.sv
module tb_dual_mode_wheel_speed_meter;
   import dmwsm_pkg::*;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int DIRECTED_ROWS   = 20;
   localparam int LONG_HOLD       = 400;
   localparam int DRAIN_CYCLES    = 60;
   localparam int MAX_REPORTS     = 40;

   // Register index outside the map; the block must ignore writes to it.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   localparam logic [63:0] FAST_SCALE = 64'(FAST_DIVISOR_DEF);

   // Pulse patterns of one request: bit 0 left wheel, bit 1 right wheel.
   localparam logic [1:0] PULSE_NONE  = 2'b00;
   localparam logic [1:0] PULSE_LEFT  = 2'b01;
   localparam logic [1:0] PULSE_RIGHT = 2'b10;
   localparam logic [1:0] PULSE_BOTH  = 2'b11;

   // One result, laid out as rsp_tdata[51:0] from the top bit down.
   typedef struct packed {
      logic        fresh_right;
      logic        fresh_left;
      logic        mode_right;
      logic        mode_left;
      logic [15:0] speed_mean;
      logic [15:0] speed_right;
      logic [15:0] speed_left;
   } tick_result_type;

   typedef struct packed {
      logic [15:0] elapsed_ms;
      logic [15:0] mode_age_ms;
      logic [15:0] pulse_count;
      logic [15:0] speed;
      logic        fast;
      logic        fresh;
   } wheel_state_type;

   typedef struct packed {
      logic            typed;
      logic [1:0]      pulses;
      tick_result_type want;
   } probe_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_addr = '0;
   logic [CSR_W-1:0]        csr_wdata = '0;

   // Predictor state and its copy of the registers
   logic [15:0]     cfg_threshold;
   logic [15:0]     cfg_window;
   logic [15:0]     cfg_toggle;
   logic [15:0]     cfg_gain_left;
   logic [15:0]     cfg_gain_right;
   logic [3:0]      tick_frac;
   wheel_state_type left_w;
   wheel_state_type right_w;

   tick_result_type expected_results [$];

   int error_count = 0;
   int results_seen = 0;
   int ticks_sent = 0;
   int recomputations = 0;
   int mode_changes = 0;
   int cycle_count = 0;
   int src_idle_pct = 0;
   int sink_idle_pct = 0;
   logic stall_arm = 1'b0;
   logic stall_started = 1'b0;
   int hold_left = 0;

   always #10 clock = ~clock;

   dual_mode_wheel_speed_meter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   function automatic logic [15:0] sat_up(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic [15:0] clip_speed(logic [63:0] v);
      return (v > 64'd65535) ? 16'hFFFF : v[15:0];
   endfunction

   // One wheel's measurement followed by its mode decision.
   function automatic wheel_state_type measure_wheel(wheel_state_type w, logic [15:0] gain);
      logic [63:0] product;
      logic [63:0] period;
      w.fresh = 1'b0;
      if (w.fast) begin
         // Fast mode scales the pulse count once the window has run out.
         if (w.elapsed_ms >= cfg_window) begin
            product = {48'd0, w.pulse_count} * {48'd0, gain};
            w.speed = clip_speed(product / FAST_SCALE);
            w.pulse_count = '0;
            w.elapsed_ms = '0;
            w.fresh = 1'b1;
         end
      end else if (w.pulse_count != 16'd0) begin
         // Slow mode divides by the elapsed time; no time at all counts as one.
         period = (w.elapsed_ms == 16'd0) ? 64'd1 : {48'd0, w.elapsed_ms};
         product = {48'd0, gain} * 64'd10 * {48'd0, w.pulse_count};
         w.speed = clip_speed(product / period);
         w.pulse_count = '0;
         w.elapsed_ms = '0;
         w.fresh = 1'b1;
      end
      if (w.mode_age_ms >= cfg_toggle) begin
         w.fast = (w.speed > cfg_threshold);
         w.mode_age_ms = '0;
      end
      return w;
   endfunction

   // Advances the predictor by one tick and forms the result it should give.
   function automatic tick_result_type predict_tick(logic [1:0] pulses);
      tick_result_type r;
      logic [16:0]     sum;
      logic            left_was_fast;
      logic            right_was_fast;
      tick_frac = tick_frac + 4'd1;
      if (tick_frac >= TICKS_PER_MS_DEF) begin
         tick_frac = '0;
         left_w.elapsed_ms = sat_up(left_w.elapsed_ms);
         left_w.mode_age_ms = sat_up(left_w.mode_age_ms);
         right_w.elapsed_ms = sat_up(right_w.elapsed_ms);
         right_w.mode_age_ms = sat_up(right_w.mode_age_ms);
      end
      if (pulses[0]) left_w.pulse_count = sat_up(left_w.pulse_count);
      if (pulses[1]) right_w.pulse_count = sat_up(right_w.pulse_count);
      left_was_fast = left_w.fast;
      right_was_fast = right_w.fast;
      left_w = measure_wheel(left_w, cfg_gain_left);
      right_w = measure_wheel(right_w, cfg_gain_right);
      recomputations += left_w.fresh + right_w.fresh;
      mode_changes += (left_w.fast != left_was_fast) + (right_w.fast != right_was_fast);
      sum = {1'b0, left_w.speed} + {1'b0, right_w.speed};
      r.speed_left = left_w.speed;
      r.speed_right = right_w.speed;
      r.speed_mean = sum[16:1];
      r.mode_left = left_w.fast;
      r.mode_right = right_w.fast;
      r.fresh_left = left_w.fresh;
      r.fresh_right = right_w.fresh;
      return r;
   endfunction

   // Directed requests, run straight after reset with the default registers.
   // Typed results: a slow wheel measures its first pulse over no elapsed time,
   // so the divisor is one and the speed is 322 * 10.
   // Typed values read fresh_right, fresh_left, mode_right, mode_left, mean,
   // right speed, left speed.
   function automatic probe_row_type probe_row(int index);
      probe_row_type r;
      r.typed = 1'b0;
      r.want = '0;
      case (index)
         0: begin
            r.pulses = PULSE_NONE;
            r.typed = 1'b1;
            r.want = {1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0};
         end
         1: begin
            r.pulses = PULSE_LEFT;
            r.typed = 1'b1;
            r.want = {1'b0, 1'b1, 1'b0, 1'b0, 16'd1610, 16'd0, 16'd3220};
         end
         2: begin
            r.pulses = PULSE_RIGHT;
            r.typed = 1'b1;
            r.want = {1'b1, 1'b0, 1'b0, 1'b0, 16'd3220, 16'd3220, 16'd3220};
         end
         3: begin
            r.pulses = PULSE_BOTH;
            r.typed = 1'b1;
            r.want = {1'b1, 1'b1, 1'b0, 1'b0, 16'd3220, 16'd3220, 16'd3220};
         end
         12, 16: r.pulses = PULSE_LEFT;
         15: r.pulses = PULSE_RIGHT;
         14, 17, 19: r.pulses = PULSE_BOTH;
         default: r.pulses = PULSE_NONE;
      endcase
      return r;
   endfunction

   task automatic report_fault(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("MISMATCH: %s", msg);
   endtask

   // Compares one taken result with the oldest expectation.
   task automatic check_result(input logic [RSP_DATA_W-1:0] data);
      tick_result_type got;
      tick_result_type want;
      got = data[51:0];
      results_seen++;
      if (expected_results.size() == 0) begin
         report_fault($sformatf("result %0d arrived with no request pending", results_seen));
      end else begin
         want = expected_results.pop_front();
         if (got.speed_left !== want.speed_left)
            report_fault($sformatf("result %0d speed_left: got %0d, expected %0d",
                                   results_seen, got.speed_left, want.speed_left));
         if (got.speed_right !== want.speed_right)
            report_fault($sformatf("result %0d speed_right: got %0d, expected %0d",
                                   results_seen, got.speed_right, want.speed_right));
         if (got.speed_mean !== want.speed_mean)
            report_fault($sformatf("result %0d speed_mean: got %0d, expected %0d",
                                   results_seen, got.speed_mean, want.speed_mean));
         if (got.mode_left !== want.mode_left)
            report_fault($sformatf("result %0d mode_left: got %b, expected %b",
                                   results_seen, got.mode_left, want.mode_left));
         if (got.mode_right !== want.mode_right)
            report_fault($sformatf("result %0d mode_right: got %b, expected %b",
                                   results_seen, got.mode_right, want.mode_right));
         if (got.fresh_left !== want.fresh_left)
            report_fault($sformatf("result %0d fresh_left: got %b, expected %b",
                                   results_seen, got.fresh_left, want.fresh_left));
         if (got.fresh_right !== want.fresh_right)
            report_fault($sformatf("result %0d fresh_right: got %b, expected %b",
                                   results_seen, got.fresh_right, want.fresh_right));
      end
      if (data[55:52] !== 4'd0)
         report_fault($sformatf("result %0d padding bits not zero: %b",
                                results_seen, data[55:52]));
   endtask

   // Writes one register and mirrors it in the predictor.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] index, input logic [CSR_W-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_THRESHOLD:  cfg_threshold = value;
         CSR_WINDOW:     cfg_window = value;
         CSR_TOGGLE:     cfg_toggle = value;
         CSR_GAIN_LEFT:  cfg_gain_left = value;
         CSR_GAIN_RIGHT: cfg_gain_right = value;
         default: ;
      endcase
   endtask

   // Offers one tick request, after a random gap, and records its expectation.
   task automatic send_tick(input logic [1:0] pulses, input logic typed,
                            input tick_result_type typed_want);
      int              gap;
      tick_result_type predicted;
      gap = 0;
      while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, pulses};
      do @(posedge clock); while (!req_tready);
      predicted = predict_tick(pulses);
      expected_results.push_back(typed ? typed_want : predicted);
      ticks_sent++;
   endtask

   // Stops offering requests until every expected result has been taken.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // Result side: checks each taken result and drives a random ready, with
   // one long hold-off to fill the block and stall its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         if (stall_arm && !stall_started) begin
            stall_started <= 1'b1;
            hold_left <= LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, expected_results.size());
         $display("simulation failed");
         $finish;
      end
   end

   // Stimulus: directed ticks, then phases of random ticks under new settings.
   initial begin
      probe_row_type row;
      logic [1:0]    pulses;
      logic [15:0]   thr;
      logic [15:0]   win;
      logic [15:0]   tog;
      logic [15:0]   gain_l;
      logic [15:0]   gain_r;
      int            pulse_pct;

      cfg_threshold = THRESHOLD_RST;
      cfg_window = WINDOW_RST;
      cfg_toggle = TOGGLE_RST;
      cfg_gain_left = GAIN_RST;
      cfg_gain_right = GAIN_RST;
      tick_frac = '0;
      left_w = '0;
      right_w = '0;

      src_idle_pct = 29;
      sink_idle_pct <= 67;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = probe_row(i);
         send_tick(row.pulses, row.typed, row.want);
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_for_drain();

         // Idle pattern: sender light and receiver heavy, then swapped, then none.
         if (p < 3) begin
            src_idle_pct = 29;
            sink_idle_pct <= 67;
         end else if (p < 6) begin
            src_idle_pct = 67;
            sink_idle_pct <= 29;
         end else begin
            src_idle_pct = 0;
            sink_idle_pct <= 0;
         end

         // Fixed settings cover the extremes; later phases are random.
         case (p)
            0: begin
               thr = 16'd10; win = 16'd2; tog = 16'd3;
               gain_l = 16'd322; gain_r = 16'd322; pulse_pct = 30;
            end
            1: begin
               thr = 16'd0; win = 16'd0; tog = 16'd0;
               gain_l = 16'hFFFF; gain_r = 16'd0; pulse_pct = 50;
            end
            2: begin
               thr = 16'hFFFF; win = 16'hFFFF; tog = 16'd1;
               gain_l = 16'd0; gain_r = 16'hFFFF; pulse_pct = 10;
            end
            3: begin
               thr = 16'd200; win = 16'd1; tog = 16'd2;
               gain_l = 16'd1000; gain_r = 16'd40000; pulse_pct = 80;
            end
            default: begin
               thr = 16'($urandom_range(0, 2000));
               win = 16'($urandom_range(0, 12));
               tog = 16'($urandom_range(0, 20));
               gain_l = 16'($urandom_range(0, 65535));
               gain_r = 16'($urandom_range(0, 65535));
               pulse_pct = $urandom_range(0, 100);
            end
         endcase

         if (p == 5) csr_write(CSR_SPARE, CSR_W'($urandom_range(0, 65535)));
         csr_write(CSR_THRESHOLD, thr);
         csr_write(CSR_WINDOW, win);
         csr_write(CSR_TOGGLE, tog);
         csr_write(CSR_GAIN_LEFT, gain_l);
         csr_write(CSR_GAIN_RIGHT, gain_r);
         csr_we <= 1'b0;

         // Long receiver hold-off while requests keep coming.
         if (p == 3) stall_arm <= 1'b1;

         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (p == 7 && i == ITEMS_PER_PHASE / 2) wait_for_drain();
            pulses[0] = ($urandom_range(0, 99) < pulse_pct);
            pulses[1] = ($urandom_range(0, 99) < pulse_pct);
            send_tick(pulses, 1'b0, '0);
         end
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d ticks under %0d register settings, from zero to full scale.",
               ticks_sent, PHASES + 1);
      $display("Checked %0d results: %0d speed recomputations, %0d mode changes, %0d faults.",
               results_seen, recomputations, mode_changes, error_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### sim.f
sv/dmwsm_pkg.sv
sv/dmwsm_ctrl.sv
sv/dmwsm_dp.sv
sv/dual_mode_wheel_speed_meter.sv
test/tb_dual_mode_wheel_speed_meter.sv
